### src/hbtq_pkg.sv
package hbtq_pkg;

  localparam int HANDLE_BITS = 16;
  localparam int EXT_BITS    = 19;
  // Operand width of the squaring stage: every distance that reaches it passes a
  // bound test against a sum of two extents, so it fits in EXT_BITS + 1 bits.
  localparam int SQ_BITS     = EXT_BITS + 1;

  typedef enum logic [1:0] {
    MODE_ADD_CIRCLE = 2'd0,
    MODE_ADD_RECT   = 2'd1,
    MODE_CLEAR      = 2'd2,
    MODE_QUERY      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_ZERO_SIZE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

endpackage

### src/hbtq_if.sv
interface hbtq_req_if #(
  parameter int COORD_BITS = 20
);
  logic                               valid;
  logic                               ready;
  logic [1:0]                         mode;
  logic [hbtq_pkg::HANDLE_BITS-1:0]   owner_handle;
  logic signed [COORD_BITS-1:0]       pos_x;
  logic signed [COORD_BITS-1:0]       pos_y;
  logic [hbtq_pkg::EXT_BITS-1:0]      extent_a;
  logic [hbtq_pkg::EXT_BITS-1:0]      extent_b;

  modport source (output valid, mode, owner_handle, pos_x, pos_y, extent_a, extent_b,
                  input ready);
  modport sink   (input valid, mode, owner_handle, pos_x, pos_y, extent_a, extent_b,
                  output ready);
endinterface

interface hbtq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [hbtq_pkg::HANDLE_BITS-1:0] hit_handle;
  logic [1:0]                       status;

  modport source (output valid, hit, hit_handle, status, input ready);
  modport sink   (input valid, hit, hit_handle, status, output ready);
endinterface

### src/hitbox_table_circle_query.sv
// Hit-area table with circle query. Add and clear requests present their result
// in the cycle after they are taken. A query reads the table memory one entry per
// cycle and feeds a four-stage test pipeline (read, distance, squaring, compare).
// A query that finds no overlap scans every entry, or none on an empty table, and
// then passes through ST_FIN to the output register. When an entry is the first to
// overlap, the scan stops as that entry reaches the compare stage, and the result
// passes through ST_FIN to the output register.
// A new request is taken only once the previous one has finished and its result
// has left or is leaving the output register.
module hitbox_table_circle_query #(
  parameter int TABLE_DEPTH = 64,
  parameter int COORD_BITS  = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hbtq_req_if.sink    req_i,
  hbtq_rsp_if.source  rsp_o
);

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int MAXW  = (COORD_BITS > hbtq_pkg::EXT_BITS) ? COORD_BITS : hbtq_pkg::EXT_BITS;
  localparam int W     = MAXW + 4;
  localparam int HB    = hbtq_pkg::HANDLE_BITS;
  localparam int EB    = hbtq_pkg::EXT_BITS;
  localparam int SB    = hbtq_pkg::SQ_BITS;

  typedef struct packed {
    logic                         is_rect;
    logic [HB-1:0]                owner;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic [EB-1:0]                ea;
    logic [EB-1:0]                eb;
  } entry_t;

  entry_t mem_q [TABLE_DEPTH];

  hbtq_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q, issue_q;
  logic signed [COORD_BITS-1:0] qx_q, qy_q;
  logic [EB-1:0] qr_q;

  entry_t rd_q;
  logic v1_q, v2_q, v3_q;
  logic pre_q, direct_q, pre3_q, direct3_q;
  logic [HB-1:0] own2_q, own3_q;
  logic [SB-1:0] a_q, b_q, r_q;
  logic [2*SB-1:0] sa_q, sb_q, sr_q;

  logic rsp_valid_q, rsp_hit_q;
  logic [HB-1:0] rsp_handle_q;
  logic [1:0] rsp_status_q;
  logic res_hit_q;
  logic [HB-1:0] res_handle_q;

  logic slot_free, accept, s4_hit, scan_empty;
  logic is_add, zero_size, table_full;

  assign slot_free = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == hbtq_pkg::ST_IDLE) && slot_free;
  assign accept = req_i.valid && req_i.ready;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.hit = rsp_hit_q;
  assign rsp_o.hit_handle = rsp_handle_q;
  assign rsp_o.status = rsp_status_q;

  assign is_add = (req_i.mode == hbtq_pkg::MODE_ADD_CIRCLE) ||
                  (req_i.mode == hbtq_pkg::MODE_ADD_RECT);
  assign zero_size = (req_i.mode == hbtq_pkg::MODE_ADD_RECT) &&
                     (req_i.extent_a == '0 || req_i.extent_b == '0);
  assign table_full = (count_q == CW'(TABLE_DEPTH));

  // Distance stage: works on the registered memory word.
  logic signed [W-1:0] qx, qy, qr, x1, y1, x2, y2, dxs, dys, xe, ye;
  logic [W-1:0] adx, ady;
  logic signed [W-1:0] rdc;
  logic pre_c, direct_c;
  logic [SB-1:0] a_c, b_c, r_c;

  always_comb begin
    qx  = W'(qx_q);
    qy  = W'(qy_q);
    qr  = W'({1'b0, qr_q});
    x1  = W'(rd_q.px);
    y1  = W'(rd_q.py);
    x2  = x1 + W'({1'b0, rd_q.ea});
    y2  = y1 + W'({1'b0, rd_q.eb});
    rdc = qr + W'({1'b0, rd_q.ea});
    xe  = ((qx <<< 1) < (x1 + x2)) ? x1 : x2;
    ye  = ((qy <<< 1) < (y1 + y2)) ? y1 : y2;
    if (rd_q.is_rect) begin
      dxs = qx - xe;
      dys = qy - ye;
    end else begin
      dxs = qx - x1;
      dys = qy - y1;
    end
    adx = (dxs < 0) ? W'(-dxs) : W'(dxs);
    ady = (dys < 0) ? W'(-dys) : W'(dys);
    if (rd_q.is_rect) begin
      pre_c    = (x1 - qr < qx) && (qx < x2 + qr) && (y1 - qr < qy) && (qy < y2 + qr);
      direct_c = ((x1 <= qx) && (qx <= x2)) || ((y1 <= qy) && (qy <= y2));
      r_c      = SB'(qr_q);
    end else begin
      pre_c    = (signed'({1'b0, adx}) < rdc) && (signed'({1'b0, ady}) < rdc);
      direct_c = 1'b0;
      r_c      = rdc[SB-1:0];
    end
    a_c = adx[SB-1:0];
    b_c = ady[SB-1:0];
  end

  assign s4_hit = v3_q && pre3_q && (direct3_q || ((2*SB+1)'(sa_q) + (2*SB+1)'(sb_q)
                  < (2*SB+1)'(sr_q)));
  assign scan_empty = (issue_q == count_q) && !v1_q && !v2_q && !v3_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      hbtq_pkg::ST_IDLE: if (accept && req_i.mode == hbtq_pkg::MODE_QUERY) begin
        state_d = hbtq_pkg::ST_SCAN;
      end
      hbtq_pkg::ST_SCAN: if (s4_hit || scan_empty) begin
        state_d = hbtq_pkg::ST_FIN;
      end
      hbtq_pkg::ST_FIN: if (slot_free) begin
        state_d = hbtq_pkg::ST_IDLE;
      end
      default: state_d = hbtq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hbtq_pkg::ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((accept && req_i.mode != hbtq_pkg::MODE_QUERY) ||
          (state_q == hbtq_pkg::ST_FIN && slot_free)) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (accept) begin
        case (req_i.mode)
          hbtq_pkg::MODE_ADD_CIRCLE, hbtq_pkg::MODE_ADD_RECT: begin
            if (!zero_size && !table_full) begin
              count_q <= count_q + 1'b1;
            end
          end
          hbtq_pkg::MODE_CLEAR: begin
            count_q <= '0;
          end
          default: issue_q <= '0;
        endcase
      end
      if (state_q == hbtq_pkg::ST_SCAN && state_d == hbtq_pkg::ST_SCAN) begin
        v1_q <= issue_q != count_q;
        v2_q <= v1_q;
        v3_q <= v2_q;
        if (issue_q != count_q) begin
          issue_q <= issue_q + 1'b1;
        end
      end else begin
        v1_q <= 1'b0;
        v2_q <= 1'b0;
        v3_q <= 1'b0;
      end
    end
  end

  // Payload, memory, pipeline and result registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qx_q <= req_i.pos_x;
      qy_q <= req_i.pos_y;
      qr_q <= req_i.extent_a;
      rsp_hit_q    <= 1'b0;
      rsp_handle_q <= '0;
      if (is_add && zero_size) begin
        rsp_status_q <= hbtq_pkg::STATUS_ZERO_SIZE;
      end else if (is_add && table_full) begin
        rsp_status_q <= hbtq_pkg::STATUS_FULL;
      end else begin
        rsp_status_q <= hbtq_pkg::STATUS_OK;
      end
      if (is_add && !zero_size && !table_full) begin
        mem_q[count_q[AW-1:0]] <= '{
          is_rect: req_i.mode == hbtq_pkg::MODE_ADD_RECT,
          owner:   req_i.owner_handle,
          px:      req_i.pos_x,
          py:      req_i.pos_y,
          ea:      req_i.extent_a,
          eb:      (req_i.mode == hbtq_pkg::MODE_ADD_RECT) ? req_i.extent_b : '0
        };
      end
    end
    rd_q      <= mem_q[issue_q[AW-1:0]];
    pre_q     <= pre_c;
    direct_q  <= direct_c;
    own2_q    <= rd_q.owner;
    a_q       <= a_c;
    b_q       <= b_c;
    r_q       <= r_c;
    sa_q      <= a_q * a_q;
    sb_q      <= b_q * b_q;
    sr_q      <= r_q * r_q;
    pre3_q    <= pre_q;
    direct3_q <= direct_q;
    own3_q    <= own2_q;
    if (state_q == hbtq_pkg::ST_SCAN) begin
      res_hit_q    <= s4_hit;
      res_handle_q <= s4_hit ? own3_q : '0;
    end
    if (state_q == hbtq_pkg::ST_FIN && slot_free) begin
      rsp_hit_q    <= res_hit_q;
      rsp_handle_q <= res_handle_q;
      rsp_status_q <= hbtq_pkg::STATUS_OK;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH)) else $error("entry count beyond table depth");

  a_pipe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != hbtq_pkg::ST_SCAN |-> !(v1_q || v2_q || v3_q))
    else $error("scan pipeline busy outside a query");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.mode == hbtq_pkg::MODE_CLEAR |=> count_q == '0)
    else $error("clear did not empty the table");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hbtq_pkg::ST_FIN && !slot_free |=> state_q == hbtq_pkg::ST_FIN)
    else $error("query result left before the output was free");

endmodule

### test/tb_hitbox_table_circle_query.sv
`timescale 1ns / 100ps

module tb_hitbox_table_circle_query;

  localparam int DEPTH = 64;
  localparam int CB    = 20;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    hbtq_pkg::mode_e      mode;
    logic [15:0]          owner;
    logic signed [CB-1:0] px;
    logic signed [CB-1:0] py;
    logic [hbtq_pkg::EXT_BITS-1:0] ea;
    logic [hbtq_pkg::EXT_BITS-1:0] eb;
  } request_t;

  typedef struct {
    logic              hit;
    logic [15:0]       handle;
    hbtq_pkg::status_e status;
    logic              fixed;  // directed row with the result typed in
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hbtq_req_if #(.COORD_BITS(CB)) req_if ();
  hbtq_rsp_if rsp_if ();

  hitbox_table_circle_query #(.TABLE_DEPTH(DEPTH), .COORD_BITS(CB)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the hit-area table.
  int unsigned     area_count;
  logic            area_rect  [DEPTH];
  logic [15:0]     area_owner [DEPTH];
  longint          area_x     [DEPTH];
  longint          area_y     [DEPTH];
  longint          area_a     [DEPTH];
  longint          area_b     [DEPTH];

  answer_t pending_answers[$];
  int      errors = 0;
  int      n_sent = 0, n_got = 0, n_hits = 0, n_refused = 0;
  int      sender_gap_pct = 0, receiver_stall_pct = 0;
  int      idle_cycles = 0;

  function automatic logic overlaps_circle(longint qx, longint qy, longint qr, int k);
    longint dx, dy, rd;
    dx = qx - area_x[k]; if (dx < 0) dx = -dx;
    dy = qy - area_y[k]; if (dy < 0) dy = -dy;
    rd = qr + area_a[k];
    if (!(dx < rd && dy < rd)) return 1'b0;
    return dx * dx + dy * dy < rd * rd;
  endfunction

  function automatic logic overlaps_rect(longint qx, longint qy, longint qr, int k);
    longint x1, x2, y1, y2, xe, ye, dx, dy;
    x1 = area_x[k]; x2 = x1 + area_a[k];
    y1 = area_y[k]; y2 = y1 + area_b[k];
    if (!(x1 - qr < qx && qx < x2 + qr && y1 - qr < qy && qy < y2 + qr)) return 1'b0;
    if ((x1 <= qx && qx <= x2) || (y1 <= qy && qy <= y2)) return 1'b1;
    xe = (2 * qx < x1 + x2) ? x1 : x2;
    ye = (2 * qy < y1 + y2) ? y1 : y2;
    dx = qx - xe; dy = qy - ye;
    return dx * dx + dy * dy < qr * qr;
  endfunction

  function automatic answer_t apply_request(request_t r);
    answer_t a;
    longint qx, qy, qr;
    a.hit = 1'b0; a.handle = '0; a.status = hbtq_pkg::STATUS_OK; a.fixed = 1'b0;
    qx = r.px; qy = r.py; qr = r.ea;
    case (r.mode)
      hbtq_pkg::MODE_ADD_CIRCLE, hbtq_pkg::MODE_ADD_RECT: begin
        if (r.mode == hbtq_pkg::MODE_ADD_RECT && (r.ea == 0 || r.eb == 0)) begin
          a.status = hbtq_pkg::STATUS_ZERO_SIZE;
        end else if (area_count >= DEPTH) begin
          a.status = hbtq_pkg::STATUS_FULL;
        end else begin
          area_rect[area_count]  = (r.mode == hbtq_pkg::MODE_ADD_RECT);
          area_owner[area_count] = r.owner;
          area_x[area_count] = qx;
          area_y[area_count] = qy;
          area_a[area_count] = qr;
          area_b[area_count] = (r.mode == hbtq_pkg::MODE_ADD_RECT) ? longint'(r.eb) : 0;
          area_count++;
        end
      end
      hbtq_pkg::MODE_CLEAR: area_count = 0;
      default: begin
        for (int k = 0; k < area_count; k++) begin
          if (area_rect[k] ? overlaps_rect(qx, qy, qr, k) : overlaps_circle(qx, qy, qr, k)) begin
            a.hit = 1'b1;
            a.handle = area_owner[k];
            break;
          end
        end
      end
    endcase
    return a;
  endfunction

  function automatic request_t make_req(hbtq_pkg::mode_e m, int unsigned own, int x, int y,
                                        int unsigned a, int unsigned b);
    request_t r;
    r.mode = m; r.owner = own[15:0]; r.px = x[CB-1:0]; r.py = y[CB-1:0];
    r.ea = a[hbtq_pkg::EXT_BITS-1:0]; r.eb = b[hbtq_pkg::EXT_BITS-1:0];
    return r;
  endfunction

  // Small coordinates most of the time so that queries actually overlap entries.
  function automatic request_t random_req(int unsigned query_pct);
    request_t r;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < query_pct) r.mode = hbtq_pkg::MODE_QUERY;
    else if (sel < 97) r.mode = ($urandom_range(1) != 0) ? hbtq_pkg::MODE_ADD_RECT
                                                          : hbtq_pkg::MODE_ADD_CIRCLE;
    else r.mode = hbtq_pkg::MODE_CLEAR;
    r.owner = $urandom;
    if ($urandom_range(9) == 0) begin
      r.px = $urandom; r.py = $urandom; r.ea = $urandom; r.eb = $urandom;
    end else begin
      r.px = $urandom_range(4000) - 2000;
      r.py = $urandom_range(4000) - 2000;
      r.ea = $urandom_range(600);
      r.eb = ($urandom_range(19) == 0) ? 0 : $urandom_range(600);
    end
    return r;
  endfunction

  // Valid stays high after a request is taken; it drops only while the sender idles.
  task automatic send_request(request_t r, answer_t typed);
    answer_t a;
    while (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.mode         <= r.mode;
    req_if.owner_handle <= r.owner;
    req_if.pos_x        <= r.px;
    req_if.pos_y        <= r.py;
    req_if.extent_a     <= r.ea;
    req_if.extent_b     <= r.eb;
    do @(posedge clk_i); while (!req_if.ready);
    a = apply_request(r);
    if (typed.fixed) begin
      if (typed.hit != a.hit || typed.handle != a.handle || typed.status != a.status) begin
        $error("typed answer disagrees with prediction for mode %s", r.mode.name());
        errors++;
      end
      a = typed;
    end
    pending_answers.push_back(a);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Result side: random stalls on ready, compare at the rising edge.
  always @(negedge clk_i) begin
    rsp_if.ready <= !(receiver_stall_pct > 0 && $urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      n_got++;
      if (pending_answers.size() == 0) begin
        $error("result arrived with nothing expected");
        errors++;
      end else begin
        e = pending_answers.pop_front();
        if (rsp_if.hit !== e.hit) begin
          $error("hit: expected %0d, got %0d", e.hit, rsp_if.hit); errors++;
        end
        if (rsp_if.hit_handle !== e.handle) begin
          $error("hit_handle: expected %0h, got %0h", e.handle, rsp_if.hit_handle); errors++;
        end
        if (rsp_if.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, rsp_if.status); errors++;
        end
        if (e.hit) n_hits++;
        if (e.status != hbtq_pkg::STATUS_OK) n_refused++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_answers.size() != 0);
  endtask

  initial begin
    request_t rows[$];
    answer_t  typed[$];
    answer_t  none, ok_add, full_add, zero_add, miss;
    int unsigned query_pct;

    none.fixed = 1'b0; none.hit = 1'b0; none.handle = '0; none.status = hbtq_pkg::STATUS_OK;
    ok_add = none; ok_add.fixed = 1'b1;
    miss = ok_add;
    full_add = ok_add; full_add.status = hbtq_pkg::STATUS_FULL;
    zero_add = ok_add; zero_add.status = hbtq_pkg::STATUS_ZERO_SIZE;

    req_if.valid = 1'b0; req_if.mode = hbtq_pkg::MODE_CLEAR; req_if.owner_handle = '0;
    req_if.pos_x = '0; req_if.pos_y = '0; req_if.extent_a = '0; req_if.extent_b = '0;
    area_count = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: empty table, zero sizes, extremes, clear.
    rows.push_back(make_req(hbtq_pkg::MODE_QUERY, 16'hFFFF, 0, 0, 524287, 0));
    typed.push_back(miss);
    rows.push_back(make_req(hbtq_pkg::MODE_ADD_RECT, 1, 0, 0, 0, 5));
    typed.push_back(zero_add);
    rows.push_back(make_req(hbtq_pkg::MODE_ADD_RECT, 2, 0, 0, 5, 0));
    typed.push_back(zero_add);
    rows.push_back(make_req(hbtq_pkg::MODE_ADD_CIRCLE, 16'hFFFF, -524288, -524288, 0, 0));
    typed.push_back(ok_add);
    rows.push_back(make_req(hbtq_pkg::MODE_ADD_RECT, 16'h0000, 524287, 524287, 524287,
                            524287));
    typed.push_back(ok_add);
    rows.push_back(make_req(hbtq_pkg::MODE_ADD_CIRCLE, 16'hA5A5, 100, 100, 50, 0));
    typed.push_back(ok_add);
    rows.push_back(make_req(hbtq_pkg::MODE_ADD_RECT, 16'h5A5A, -300, -300, 100, 60));
    typed.push_back(ok_add);
    rows.push_back(make_req(hbtq_pkg::MODE_QUERY, 0, -524288, -524288, 0, 0));
    typed.push_back(none);
    rows.push_back(make_req(hbtq_pkg::MODE_QUERY, 0, -524288, -524288, 1, 0));
    typed.push_back(none);
    rows.push_back(make_req(hbtq_pkg::MODE_QUERY, 0, 524287, 524287, 524287, 524287));
    typed.push_back(none);
    rows.push_back(make_req(hbtq_pkg::MODE_QUERY, 0, 100, 160, 10, 0));
    typed.push_back(none);
    rows.push_back(make_req(hbtq_pkg::MODE_QUERY, 0, 100, 159, 10, 0));
    typed.push_back(none);
    rows.push_back(make_req(hbtq_pkg::MODE_QUERY, 0, -210, -250, 20, 0));
    typed.push_back(none);
    rows.push_back(make_req(hbtq_pkg::MODE_QUERY, 0, -180, -220, 20, 0));
    typed.push_back(none);
    rows.push_back(make_req(hbtq_pkg::MODE_QUERY, 0, -190, -230, 20, 0));
    typed.push_back(none);
    rows.push_back(make_req(hbtq_pkg::MODE_QUERY, 0, -320, -250, 20, 0));
    typed.push_back(none);
    rows.push_back(make_req(hbtq_pkg::MODE_CLEAR, 16'hFFFF, -1, -1, 524287, 524287));
    typed.push_back(ok_add);
    rows.push_back(make_req(hbtq_pkg::MODE_QUERY, 0, 100, 100, 50, 0));
    typed.push_back(miss);
    foreach (rows[i]) send_request(rows[i], typed[i]);

    // Fill to capacity, one refused add of each kind, a deep query.
    for (int i = 0; i < DEPTH; i++)
      send_request(make_req(hbtq_pkg::MODE_ADD_CIRCLE, i, 5000 + 40 * i, 5000, 10, 0), none);
    send_request(make_req(hbtq_pkg::MODE_ADD_CIRCLE, 7, 0, 0, 1, 0), full_add);
    send_request(make_req(hbtq_pkg::MODE_ADD_RECT, 7, 0, 0, 1, 1), full_add);
    send_request(make_req(hbtq_pkg::MODE_ADD_RECT, 7, 0, 0, 0, 1), zero_add);
    send_request(make_req(hbtq_pkg::MODE_QUERY, 0, 5000 + 40 * 63, 5000, 5, 0), none);
    send_request(make_req(hbtq_pkg::MODE_QUERY, 0, 0, 0, 5, 0), none);
    send_request(make_req(hbtq_pkg::MODE_CLEAR, 0, 0, 0, 0, 0), none);

    // Random phases with different idling on each side; the sender drains once per phase.
    for (int phase = 0; phase < 3; phase++) begin
      sender_gap_pct     = (phase == 0) ? 14 : (phase == 1) ? 53 : 0;
      receiver_stall_pct = (phase == 0) ? 53 : (phase == 1) ? 14 : 0;
      for (int i = 0; i < 275; i++) begin
        query_pct = (area_count < 8) ? 30 : 60;
        send_request(random_req(query_pct), none);
        if (i == 150) wait_drained();
      end
    end

    wait_drained();
    repeat (DEPTH + 20) @(negedge clk_i);
    $display("Covered %0d requests and %0d results: %0d hits, %0d refused adds.",
             n_sent, n_got, n_hits, n_refused);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
